>>> hw/rtl/pcd_pkg.sv
// Shared types, codes and helpers for the chunk deframer.
package pcd_pkg;

   // Result kinds (travel on rsp_tuser).
   localparam logic [1:0] KIND_DATA    = 2'd0;
   localparam logic [1:0] KIND_PALETTE = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;

   // Chunk kind codes.
   localparam logic [2:0] CK_IHDR  = 3'd0;
   localparam logic [2:0] CK_PLTE  = 3'd1;
   localparam logic [2:0] CK_IDAT  = 3'd2;
   localparam logic [2:0] CK_IEND  = 3'd3;
   localparam logic [2:0] CK_OTHER = 3'd4;

   // Four-character chunk type tags, big-endian ASCII.
   localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
   localparam logic [31:0] TYPE_PLTE = 32'h504C_5445;
   localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
   localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

   localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
   localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;

   // Result word, payload in the lowest bits.
   typedef struct packed {
      logic [5:0]  pad;
      logic [7:0]  interlace_mode;
      logic [7:0]  filter_mode;
      logic [7:0]  compress_mode;
      logic [7:0]  color_mode;
      logic [7:0]  sample_depth;
      logic [30:0] image_height;
      logic [30:0] image_width;
      logic        crc_ok;
      logic [2:0]  chunk_kind;
      logic [7:0]  palette_slot;
      logic [23:0] payload;
   } rsp_data_type;

   typedef struct packed {
      logic init;
      logic update;
   } crc_ctl_type;

   function automatic logic [2:0] chunk_kind_of(input logic [31:0] tag);
      logic [2:0] k;
      if (tag == TYPE_IHDR)      k = CK_IHDR;
      else if (tag == TYPE_PLTE) k = CK_PLTE;
      else if (tag == TYPE_IDAT) k = CK_IDAT;
      else if (tag == TYPE_IEND) k = CK_IEND;
      else                       k = CK_OTHER;
      return k;
   endfunction

endpackage

>>> hw/rtl/pcd_crc32.sv
// Running reflected CRC-32 register, one byte per update.
module pcd_crc32 (
   input  logic                clock,
   input  logic                reset,
   input  pcd_pkg::crc_ctl_type ctl,
   input  logic [7:0]          data_byte,
   output logic [31:0]         crc
);
   import pcd_pkg::*;

   logic [31:0] crc_ff;
   logic [31:0] crc_in;
   logic [31:0] folded;

   always_comb begin
      folded = crc_ff ^ {24'd0, data_byte};
      for (int i = 0; i < 8; i++) begin
         folded = folded[0] ? ((folded >> 1) ^ CRC_POLY) : (folded >> 1);
      end
      if (ctl.init) begin
         crc_in = CRC_PRESET;
      end else if (ctl.update) begin
         crc_in = folded;
      end else begin
         crc_in = crc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_PRESET;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc = crc_ff;

endmodule

>>> hw/rtl/pcd_parser.sv
// Chunk framing state, header capture, palette assembly and result formation.
module pcd_parser #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            data_byte,
   output logic                  result_valid,
   output logic [1:0]            result_kind,
   output pcd_pkg::rsp_data_type result_data
);
   import pcd_pkg::*;

   localparam int COUNT_W = $clog2(PALETTE_ENTRIES + 1);

   localparam logic [1:0] SEC_LEN  = 2'd0;
   localparam logic [1:0] SEC_TYPE = 2'd1;
   localparam logic [1:0] SEC_DATA = 2'd2;
   localparam logic [1:0] SEC_CRC  = 2'd3;

   logic [1:0]         section_ff, section_in;
   logic [31:0]        byte_count_ff, byte_count_in;
   logic [31:0]        chunk_length_ff, chunk_length_in;
   logic [31:0]        chunk_type_ff, chunk_type_in;
   logic [31:0]        received_crc_ff, received_crc_in;
   logic [15:0]        partial_rgb_ff, partial_rgb_in;
   logic [1:0]         phase_ff, phase_in;
   logic [COUNT_W-1:0] palette_count_ff, palette_count_in;
   logic [30:0]        header_width_ff, header_width_in;
   logic [30:0]        header_height_ff, header_height_in;
   logic [39:0]        header_bytes_ff, header_bytes_in;
   logic               halted_ff, halted_in;

   logic [31:0]  byte_count_inc;
   logic [31:0]  running_crc;
   logic         crc_match;
   crc_ctl_type  crc_ctl;

   pcd_crc32 u_crc (
      .clock     (clock),
      .reset     (reset),
      .ctl       (crc_ctl),
      .data_byte (data_byte),
      .crc       (running_crc)
   );

   assign byte_count_inc = byte_count_ff + 32'd1;

   always_comb begin
      section_in       = section_ff;
      byte_count_in    = byte_count_ff;
      chunk_length_in  = chunk_length_ff;
      chunk_type_in    = chunk_type_ff;
      received_crc_in  = received_crc_ff;
      partial_rgb_in   = partial_rgb_ff;
      phase_in         = phase_ff;
      palette_count_in = palette_count_ff;
      header_width_in  = header_width_ff;
      header_height_in = header_height_ff;
      header_bytes_in  = header_bytes_ff;
      halted_in        = halted_ff;
      crc_ctl          = '0;
      crc_match        = 1'b0;

      result_valid              = 1'b0;
      result_kind               = KIND_DATA;
      result_data               = '0;
      result_data.chunk_kind    = chunk_kind_of(chunk_type_ff);
      result_data.image_width   = header_width_ff;
      result_data.image_height  = header_height_ff;
      result_data.sample_depth  = header_bytes_ff[39:32];
      result_data.color_mode    = header_bytes_ff[31:24];
      result_data.compress_mode = header_bytes_ff[23:16];
      result_data.filter_mode   = header_bytes_ff[15:8];
      result_data.interlace_mode = header_bytes_ff[7:0];

      if (step && !halted_ff) begin
         unique case (section_ff)
            SEC_LEN: begin
               chunk_length_in = {chunk_length_ff[23:0], data_byte};
               if (byte_count_ff == 32'd3) begin
                  section_in    = SEC_TYPE;
                  byte_count_in = '0;
                  crc_ctl.init  = 1'b1;
               end else begin
                  byte_count_in = byte_count_inc;
               end
            end
            SEC_TYPE: begin
               chunk_type_in  = {chunk_type_ff[23:0], data_byte};
               crc_ctl.update = 1'b1;
               if (byte_count_ff == 32'd3) begin
                  byte_count_in   = '0;
                  received_crc_in = '0;
                  partial_rgb_in  = '0;
                  phase_in        = '0;
                  if (chunk_type_in == TYPE_PLTE) begin
                     palette_count_in = '0;
                  end
                  section_in = (chunk_length_ff == 32'd0) ? SEC_CRC : SEC_DATA;
               end else begin
                  byte_count_in = byte_count_inc;
               end
            end
            SEC_DATA: begin
               crc_ctl.update = 1'b1;
               if (chunk_type_ff == TYPE_IDAT) begin
                  result_valid        = 1'b1;
                  result_kind         = KIND_DATA;
                  result_data.payload = {16'd0, data_byte};
               end else if (chunk_type_ff == TYPE_PLTE) begin
                  phase_in = (phase_ff == 2'd2) ? 2'd0 : phase_ff + 2'd1;
                  case (phase_ff)
                     2'd0: partial_rgb_in = {data_byte, 8'd0};
                     2'd1: partial_rgb_in = {partial_rgb_ff[15:8], data_byte};
                     default: begin
                        // blue byte completes an entry; surplus entries drop
                        if (palette_count_ff < COUNT_W'(PALETTE_ENTRIES)) begin
                           result_valid             = 1'b1;
                           result_kind              = KIND_PALETTE;
                           result_data.payload      = {partial_rgb_ff, data_byte};
                           result_data.palette_slot = 8'(palette_count_ff);
                           palette_count_in         = palette_count_ff + 1'b1;
                        end
                        partial_rgb_in = '0;
                     end
                  endcase
               end else if (chunk_type_ff == TYPE_IHDR) begin
                  if (byte_count_ff[31:4] == 28'd0) begin
                     case (byte_count_ff[3:0])
                        4'd0:  header_width_in[30:24]  = data_byte[6:0];
                        4'd1:  header_width_in[23:16]  = data_byte;
                        4'd2:  header_width_in[15:8]   = data_byte;
                        4'd3:  header_width_in[7:0]    = data_byte;
                        4'd4:  header_height_in[30:24] = data_byte[6:0];
                        4'd5:  header_height_in[23:16] = data_byte;
                        4'd6:  header_height_in[15:8]  = data_byte;
                        4'd7:  header_height_in[7:0]   = data_byte;
                        4'd8:  header_bytes_in[39:32]  = data_byte;
                        4'd9:  header_bytes_in[31:24]  = data_byte;
                        4'd10: header_bytes_in[23:16]  = data_byte;
                        4'd11: header_bytes_in[15:8]   = data_byte;
                        4'd12: header_bytes_in[7:0]    = data_byte;
                        default: ;
                     endcase
                  end
               end
               if (byte_count_inc == chunk_length_ff) begin
                  byte_count_in = '0;
                  section_in    = SEC_CRC;
               end else begin
                  byte_count_in = byte_count_inc;
               end
            end
            SEC_CRC: begin
               received_crc_in = {received_crc_ff[23:0], data_byte};
               if (byte_count_ff == 32'd3) begin
                  crc_match          = (~running_crc) == received_crc_in;
                  result_valid       = 1'b1;
                  result_kind        = KIND_END;
                  result_data.crc_ok = crc_match;
                  if (!crc_match || chunk_type_ff == TYPE_IEND) begin
                     halted_in = 1'b1;
                  end
                  section_in      = SEC_LEN;
                  byte_count_in   = '0;
                  chunk_length_in = '0;
               end else begin
                  byte_count_in = byte_count_inc;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         section_ff       <= SEC_LEN;
         byte_count_ff    <= '0;
         chunk_length_ff  <= '0;
         chunk_type_ff    <= '0;
         received_crc_ff  <= '0;
         partial_rgb_ff   <= '0;
         phase_ff         <= '0;
         palette_count_ff <= '0;
         header_width_ff  <= '0;
         header_height_ff <= '0;
         header_bytes_ff  <= '0;
         halted_ff        <= 1'b0;
      end else begin
         section_ff       <= section_in;
         byte_count_ff    <= byte_count_in;
         chunk_length_ff  <= chunk_length_in;
         chunk_type_ff    <= chunk_type_in;
         received_crc_ff  <= received_crc_in;
         partial_rgb_ff   <= partial_rgb_in;
         phase_ff         <= phase_in;
         palette_count_ff <= palette_count_in;
         header_width_ff  <= header_width_in;
         header_height_ff <= header_height_in;
         header_bytes_ff  <= header_bytes_in;
         halted_ff        <= halted_in;
      end
   end

endmodule

>>> hw/rtl/png_chunk_deframer.sv
// Top level of the chunk deframer: input register, parser and result register.
//
// Usage
//   req channel: one stream byte per transfer (the file after its 8-byte
//   signature). rsp channel: zero or one result per byte - an image data
//   byte, an assembled palette entry, or a chunk end carrying the CRC-32
//   verdict. Every result also carries the chunk kind and the header fields
//   captured so far.
//   Flow: a transfer loads its byte into the input register; when that byte can
//   move on, its result, if any, is loaded into the result register for rsp.
//   Throughput: one byte per cycle unless rsp stalls; between the two registers
//   sit one byte-wide CRC-32 update, the length/count compare and the field muxes.
//   A new byte is taken while a finished result waits, as long as the input
//   register is empty or its byte can move on.
//   Stall: when rsp_tready is low with a result pending, the input register
//   holds its byte and req_tready drops once it is full. No result is lost.
//   A bad CRC, or a good end-of-image chunk, halts the block: later bytes
//   are still transferred but give no result until reset.
//   Reset (synchronous, active high) returns to expecting a chunk length and
//   clears captured header fields.
module png_chunk_deframer #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: [7:0] stream_byte
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,
   // rsp_tdata, low bit up: [23:0] payload, [31:24] palette_slot,
   // [34:32] chunk_kind, [35] crc_ok, [66:36] image_width,
   // [97:67] image_height, [105:98] sample_depth, [113:106] color_mode,
   // [121:114] compress_mode, [129:122] filter_mode,
   // [137:130] interlace_mode, [143:138] zero
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,
   // rsp_tuser: [1:0] kind
   output logic [1:0]   rsp_tuser
);
   import pcd_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff, in_byte_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;
   logic [1:0]   rsp_kind_ff, rsp_kind_in;

   logic         advance;
   logic         req_xfer;
   logic         result_valid;
   logic [1:0]   result_kind;
   rsp_data_type result_data;

   // byte leaves the input register when the result register is free
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   pcd_parser #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .data_byte    (in_byte_ff),
      .result_valid (result_valid),
      .result_kind  (result_kind),
      .result_data  (result_data)
   );

   always_comb begin
      in_byte_in  = in_byte_ff;
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      if (advance && result_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result_data;
         rsp_kind_in  = result_kind;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_byte_ff  <= in_byte_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   // a failed chunk end is the last result until reset
   a_halt_after_bad_crc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser == KIND_END && !rsp_data_ff.crc_ok
      |=> !rsp_tvalid)
      else $error("result after a failed CRC check");

   // a blocked byte stays in the input register
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input register lost a blocked byte");

   // palette results stay inside the table and carry no CRC verdict
   a_palette_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_PALETTE
      |-> 32'(rsp_data_ff.palette_slot) < PALETTE_ENTRIES && !rsp_data_ff.crc_ok)
      else $error("palette result out of range");

endmodule
